### rtl/core/itf_pkg.sv
// itf_pkg: shared types, character constants and helpers for the integer to text formatter
// no dependencies; imported by every module of the formatter
`default_nettype none

package itf_pkg;

	// conversion codes as carried in the item
	typedef enum logic [2:0] {
		CONV_SDEC = 3'd0,
		CONV_SOCT = 3'd1,
		CONV_UDEC = 3'd2,
		CONV_HEX  = 3'd3,
		CONV_PTR  = 3'd4
	} itf_conv_t;

	// digit layout selected when the digit register is loaded
	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_OCT,
		RADIX_HEX
	} itf_radix_t;

	localparam int VALUE_W    = 64;
	localparam int NUM_SLOTS  = 22;              // octal of 2^64-1 needs 22 digits
	localparam int DIG_W      = NUM_SLOTS * 4;
	localparam int DEC_DIGITS = 20;
	localparam int DEC_W      = DEC_DIGITS * 4;
	localparam int OCT_DIGITS = 22;
	localparam int HEX_DIGITS = 16;
	localparam int NDIG_W     = 5;
	localparam int STEP_W     = 6;               // one dabble step per value bit

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_A     = 8'h41;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [2:0]         conversion;
		logic [6:0]         field_width;
		logic               left_align;
		logic               zero_pad;
	} itf_in_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} itf_out_t;

	// commands from the sequencer to the digit unit
	typedef struct packed {
		logic       load;
		itf_radix_t radix;
		logic       negate;
		logic       dabble;
		logic       shift;
	} itf_dcmd_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'h0, d};
		end else begin
			c = CH_A + {4'h0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/core/integer_to_text_formatter_top.sv
// integer_to_text_formatter_top: printf-style integer formatter, one character per transfer
// depends on itf_pkg, itf_digit_unit, itf_seq
//
//  channel   signals                               direction  carries
//  item      item_valid / item_ready / item_data   in         value, conversion, width, flags
//  text      text_valid / text_ready / text_data   out        character, last
//
// sequence: decimal takes 64 double-dabble steps in the shared digit unit, then a zero strip
//   that keeps at least one digit, a sizing state and the characters, one per transfer
// octal and hex skip the dabble steps and strip leading zeros from 22 and 16 digits
// the field width is clamped to MAX_FIELD_WIDTH; an unknown conversion is taken and dropped
// reset clears the sequencer and the output valid flag; output data and digit storage are not reset
// a stalled text channel holds the sequencer; a new item is taken only when it is idle
`default_nettype none

module integer_to_text_formatter_top #(
	parameter int MAX_FIELD_WIDTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire itf_pkg::itf_in_t  item_data,
	output logic                   text_valid,
	input  wire logic              text_ready,
	output itf_pkg::itf_out_t      text_data
);
	import itf_pkg::*;

	itf_dcmd_t  dcmd;
	logic [3:0] top_digit;
	logic       emit;
	logic       emit_ok;
	itf_out_t   emit_data;
	logic       text_valid_q;
	itf_out_t   text_data_q;

	// shared digit register: bcd dabble, octal/hex load, digit shift
	itf_digit_unit u_digit (
		.clk       (clk),
		.cmd       (dcmd),
		.value     (item_data.value),
		.top_digit (top_digit)
	);

	// sequencer: conversion, zero strip, sizing, then pad / sign / prefix / digits / pad
	itf_seq #(
		.MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item_data),
		.item_ready (item_ready),
		.top_digit  (top_digit),
		.emit_ok    (emit_ok),
		.emit       (emit),
		.emit_data  (emit_data),
		.dcmd       (dcmd)
	);

	// output register: refilled in the same cycle its transfer completes
	assign emit_ok = !text_valid_q || text_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid_q <= 1'b0;
		end else if (emit && emit_ok) begin
			text_valid_q <= 1'b1;
		end else if (text_ready) begin
			text_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && emit_ok) begin
			text_data_q <= emit_data;
		end
	end

	assign text_valid = text_valid_q;
	assign text_data  = text_data_q;

endmodule

`default_nettype wire

### rtl/core/itf_digit_unit.sv
// itf_digit_unit: digit register with one shared shift / add-3 step unit
// depends on itf_pkg
`default_nettype none

module itf_digit_unit (
	input  wire logic                       clk,
	input  wire itf_pkg::itf_dcmd_t         cmd,
	input  wire logic [itf_pkg::VALUE_W-1:0] value,
	output logic [3:0]                      top_digit
);
	import itf_pkg::*;

	logic [DIG_W-1:0]   dig_q;
	logic [VALUE_W-1:0] bin_q;
	logic [VALUE_W-1:0] mag;
	logic [VALUE_W+1:0] mag_ext;
	logic [DIG_W-1:0]   oct_img;
	logic [DEC_W-1:0]   adj;

	always_comb begin
		mag     = cmd.negate ? (VALUE_W'(0) - value) : value;
		mag_ext = {2'b00, mag};
		for (int i = 0; i < NUM_SLOTS; i++) begin
			oct_img[4*i +: 4] = {1'b0, mag_ext[3*i +: 3]};
		end
	end

	// add 3 to every bcd digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			if (dig_q[DIG_W-DEC_W+4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = dig_q[DIG_W-DEC_W+4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = dig_q[DIG_W-DEC_W+4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= mag;
			unique case (cmd.radix)
				RADIX_OCT: dig_q <= oct_img;
				RADIX_HEX: dig_q <= {mag, (DIG_W-VALUE_W)'(0)};
				default:   dig_q <= '0;
			endcase
		end else if (cmd.dabble) begin
			dig_q[DIG_W-1 -: DEC_W] <= {adj[DEC_W-2:0], bin_q[VALUE_W-1]};
			bin_q                   <= {bin_q[VALUE_W-2:0], 1'b0};
		end else if (cmd.shift) begin
			dig_q <= {dig_q[DIG_W-5:0], 4'h0};
		end
	end

	assign top_digit = dig_q[DIG_W-1 -: 4];

endmodule

`default_nettype wire

### rtl/core/itf_seq.sv
// itf_seq: sequencer that steers the digit unit and builds the character stream
// depends on itf_pkg
`default_nettype none

module itf_seq #(
	parameter int MAX_FIELD_WIDTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire itf_pkg::itf_in_t   item,
	output logic                    item_ready,
	input  wire logic [3:0]         top_digit,
	input  wire logic               emit_ok,
	output logic                    emit,
	output itf_pkg::itf_out_t       emit_data,
	output itf_pkg::itf_dcmd_t      dcmd
);
	import itf_pkg::*;

	localparam int CNT_W = $clog2(MAX_FIELD_WIDTH + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DABBLE,
		S_NORM,
		S_SIZE,
		S_PAD_PRE,
		S_SIGN,
		S_PFX0,
		S_PFX1,
		S_DIGITS,
		S_PAD_POST
	} state_t;

	state_t             state_q;
	state_t             head_c;
	logic               neg_q;
	logic               ptr_q;
	logic               left_q;
	logic               zpad_q;
	logic [CNT_W-1:0]   width_q;
	logic [CNT_W-1:0]   pad_q;
	logic [CNT_W-1:0]   rem_q;
	logic [NDIG_W-1:0]  ndig_q;
	logic [STEP_W-1:0]  step_q;
	logic               is_signed;
	logic               valid_conv;
	logic [CNT_W-1:0]   width_c;
	logic [NDIG_W-1:0]  len_c;
	logic [CNT_W-1:0]   lenw_c;
	logic [CNT_W-1:0]   pad_c;
	logic [CNT_W-1:0]   total_c;
	logic               fire;

	always_comb begin
		is_signed  = (item.conversion == CONV_SDEC) || (item.conversion == CONV_SOCT);
		valid_conv = (item.conversion <= CONV_PTR);
		if (item.field_width > 7'(MAX_FIELD_WIDTH)) begin
			width_c = CNT_W'(MAX_FIELD_WIDTH);
		end else begin
			width_c = CNT_W'(item.field_width);
		end

		len_c   = ndig_q + {{(NDIG_W-1){1'b0}}, neg_q} + {{(NDIG_W-2){1'b0}}, ptr_q, 1'b0};
		lenw_c  = CNT_W'(len_c);
		pad_c   = (width_q > lenw_c) ? (width_q - lenw_c) : '0;
		total_c = (width_q > lenw_c) ? width_q : lenw_c;

		if (neg_q) begin
			head_c = S_SIGN;
		end else if (ptr_q) begin
			head_c = S_PFX0;
		end else begin
			head_c = S_DIGITS;
		end
	end

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		emit_data.last = (rem_q == CNT_W'(1));
		unique case (state_q)
			S_PAD_PRE: begin
				emit                = 1'b1;
				emit_data.character = zpad_q ? CH_ZERO : CH_SPACE;
			end
			S_SIGN: begin
				emit                = 1'b1;
				emit_data.character = CH_MINUS;
			end
			S_PFX0: begin
				emit                = 1'b1;
				emit_data.character = CH_ZERO;
			end
			S_PFX1: begin
				emit                = 1'b1;
				emit_data.character = CH_X;
			end
			S_DIGITS: begin
				emit                = 1'b1;
				emit_data.character = digit_char(top_digit);
			end
			S_PAD_POST: begin
				emit                = 1'b1;
				emit_data.character = CH_SPACE;
			end
			default: begin
				emit                = 1'b0;
				emit_data.character = CH_SPACE;
			end
		endcase
		fire = emit && emit_ok;
	end

	always_comb begin
		dcmd.load   = item_valid && (state_q == S_IDLE);
		dcmd.negate = is_signed && item.value[VALUE_W-1];
		if ((item.conversion == CONV_SDEC) || (item.conversion == CONV_UDEC)) begin
			dcmd.radix = RADIX_DEC;
		end else if (item.conversion == CONV_SOCT) begin
			dcmd.radix = RADIX_OCT;
		end else begin
			dcmd.radix = RADIX_HEX;
		end
		dcmd.dabble = (state_q == S_DABBLE);
		dcmd.shift  = ((state_q == S_NORM) && (ndig_q > NDIG_W'(1)) && (top_digit == 4'h0))
			|| ((state_q == S_DIGITS) && fire);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			neg_q   <= 1'b0;
			ptr_q   <= 1'b0;
			left_q  <= 1'b0;
			zpad_q  <= 1'b0;
			width_q <= '0;
			pad_q   <= '0;
			rem_q   <= '0;
			ndig_q  <= '0;
			step_q  <= '0;
		end else begin
			if (fire) begin
				rem_q <= rem_q - CNT_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid && valid_conv) begin
						neg_q   <= dcmd.negate;
						ptr_q   <= (item.conversion == CONV_PTR);
						left_q  <= item.left_align;
						zpad_q  <= item.zero_pad;
						width_q <= width_c;
						step_q  <= '0;
						unique case (dcmd.radix)
							RADIX_DEC: begin
								ndig_q  <= NDIG_W'(DEC_DIGITS);
								state_q <= S_DABBLE;
							end
							RADIX_OCT: begin
								ndig_q  <= NDIG_W'(OCT_DIGITS);
								state_q <= S_NORM;
							end
							default: begin
								ndig_q  <= NDIG_W'(HEX_DIGITS);
								state_q <= S_NORM;
							end
						endcase
					end
				end
				S_DABBLE: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == '1) begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					// drop leading zero digits, keep at least one
					if (dcmd.shift) begin
						ndig_q <= ndig_q - NDIG_W'(1);
					end else begin
						state_q <= S_SIZE;
					end
				end
				S_SIZE: begin
					pad_q <= pad_c;
					rem_q <= total_c;
					if (!left_q && (pad_c != '0)) begin
						state_q <= S_PAD_PRE;
					end else begin
						state_q <= head_c;
					end
				end
				S_PAD_PRE: begin
					if (fire) begin
						pad_q <= pad_q - CNT_W'(1);
						if (pad_q == CNT_W'(1)) begin
							state_q <= head_c;
						end
					end
				end
				S_SIGN: begin
					if (fire) begin
						state_q <= S_DIGITS;
					end
				end
				S_PFX0: begin
					if (fire) begin
						state_q <= S_PFX1;
					end
				end
				S_PFX1: begin
					if (fire) begin
						state_q <= S_DIGITS;
					end
				end
				S_DIGITS: begin
					if (fire) begin
						ndig_q <= ndig_q - NDIG_W'(1);
						if (ndig_q == NDIG_W'(1)) begin
							state_q <= (left_q && (pad_q != '0)) ? S_PAD_POST : S_IDLE;
						end
					end
				end
				S_PAD_POST: begin
					if (fire) begin
						pad_q <= pad_q - CNT_W'(1);
						if (pad_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/itf_checker.sv
// itf_checker: port-level checks for the integer to text formatter, bound to the top level
// depends on itf_pkg and integer_to_text_formatter_top
`default_nettype none

module itf_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_valid,
	input wire logic              item_ready,
	input wire itf_pkg::itf_in_t  item_data,
	input wire logic              text_valid,
	input wire logic              text_ready,
	input wire itf_pkg::itf_out_t text_data
);
	import itf_pkg::*;

	// a stalled character holds
	a_text_hold: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_ready |=> text_valid && $stable(text_data))
		else $error("text transfer changed while stalled");

	// a known conversion keeps the block busy in the next cycle
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_data.conversion <= CONV_PTR) |=> !item_ready)
		else $error("item taken while a field is in progress");

	// an unknown conversion is dropped and leaves the block idle
	a_drop_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_data.conversion > CONV_PTR) |=> item_ready)
		else $error("unknown conversion started a field");

	// more characters follow a transfer that is not the last one
	a_field_open: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_ready && !text_data.last |-> !item_ready)
		else $error("field ended without a last character");

endmodule

bind integer_to_text_formatter_top itf_checker u_itf_checker (.*);

`default_nettype wire
